[rtl/ghs_pkg.sv]
package ghs_pkg;

   // number of member bytes held back as the trailer
   localparam int unsigned TRAILER_BYTES = 8;
   localparam int unsigned FILL_W        = $clog2(TRAILER_BYTES + 1);

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // fixed header bytes
   localparam logic [7:0] SIG_ID1     = 8'h1F;
   localparam logic [7:0] SIG_ID2     = 8'h8B;
   localparam logic [7:0] SIG_DEFLATE = 8'h08;
   localparam logic [3:0] FIXED_LAST  = 4'd9;
   localparam logic [3:0] FLAG_INDEX  = 4'd3;

   // flag bits
   localparam int unsigned FL_HCRC    = 1;
   localparam int unsigned FL_EXTRA   = 2;
   localparam int unsigned FL_NAME    = 3;
   localparam int unsigned FL_COMMENT = 4;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_END_OK    = 3'd1;
   localparam logic [2:0] KIND_BAD_SIG   = 3'd2;
   localparam logic [2:0] KIND_TRUNCATED = 3'd3;
   localparam logic [2:0] KIND_TOO_SHORT = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_final;
   } ghs_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] kind;
      logic       member_done;
   } ghs_rsp_type;

   // up to two results produced by one input transfer, in order
   typedef struct packed {
      logic        first_valid;
      logic        second_valid;
      ghs_rsp_type first;
      ghs_rsp_type second;
   } ghs_push_type;

endpackage

[rtl/gzip_header_stripper.sv]
// results are registered: each one enters the result queue with the input transfer that causes it
// throughput: one byte per cycle; the final byte of a member may add a second result,
//   drained from a four-entry result queue that accepts input while it has room for two
// reset: synchronous, active high; clears parser state and empties the result queue,
//   the trailer delay line itself is not cleared
module gzip_header_stripper
   import ghs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ghs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ghs_rsp_type rsp_data
);

   ghs_push_type push;
   logic         room;
   logic         take;

   // input transfer
   assign req_stall = !room;
   assign take      = req_valid && room;

   ghs_parser u_parser (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push)
   );

   ghs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/ghs_parser.sv]
module ghs_parser
   import ghs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  ghs_req_type  req,
   output ghs_push_type push
);

   typedef enum logic [2:0] {
      PH_FIXED   = 3'd0,
      PH_XLEN    = 3'd1,
      PH_EXTRA   = 3'd2,
      PH_NAME    = 3'd3,
      PH_COMMENT = 3'd4,
      PH_HCRC    = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_DROP    = 3'd7
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [3:0]        count_ff, count_in;
   logic [4:0]        flags_ff, flags_in;
   logic [15:0]       xlen_ff, xlen_in;
   logic [16:0]       xcnt_ff, xcnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              seen_ff, seen_in;
   logic [7:0]        delay_ff [TRAILER_BYTES];
   logic [7:0]        delay_in [TRAILER_BYTES];
   logic              bad;
   logic [2:0]        end_kind;

   // first header part after the given one that the flags ask for
   function automatic phase_type next_part(input phase_type stage, input logic [4:0] fl);
      phase_type nxt;
      if (stage < PH_XLEN && fl[FL_EXTRA])
         nxt = PH_XLEN;
      else if (stage < PH_NAME && fl[FL_NAME])
         nxt = PH_NAME;
      else if (stage < PH_COMMENT && fl[FL_COMMENT])
         nxt = PH_COMMENT;
      else if (stage < PH_HCRC && fl[FL_HCRC])
         nxt = PH_HCRC;
      else
         nxt = PH_PAYLOAD;
      return nxt;
   endfunction

   // per-byte parse step
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      xlen_in  = xlen_ff;
      xcnt_in  = xcnt_ff;
      fill_in  = fill_ff;
      seen_in  = seen_ff;
      delay_in = delay_ff;
      bad      = 1'b0;
      end_kind = KIND_TRUNCATED;

      push.first_valid  = 1'b0;
      push.second_valid = 1'b0;
      push.first        = '0;
      push.second       = '0;

      if (take) begin
         case (phase_ff)
            PH_FIXED: begin
               if (count_ff == 4'd0 && req.in_byte != SIG_ID1) bad = 1'b1;
               if (count_ff == 4'd1 && req.in_byte != SIG_ID2) bad = 1'b1;
               if (count_ff == 4'd2 && req.in_byte != SIG_DEFLATE) bad = 1'b1;
               if (count_ff == FLAG_INDEX) flags_in = req.in_byte[4:0];
               if (bad) begin
                  phase_in = PH_DROP;
               end else if (count_ff >= FIXED_LAST) begin
                  phase_in = next_part(PH_FIXED, flags_in);
                  count_in = 4'd0;
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            PH_XLEN: begin
               if (count_ff == 4'd0) begin
                  xlen_in  = {8'd0, req.in_byte};
                  count_in = 4'd1;
               end else begin
                  xlen_in  = {req.in_byte, xlen_ff[7:0]};
                  count_in = 4'd0;
                  xcnt_in  = '0;
                  if (xlen_in == 16'd0)
                     phase_in = next_part(PH_EXTRA, flags_ff);
                  else
                     phase_in = PH_EXTRA;
               end
            end
            PH_EXTRA: begin
               xcnt_in = xcnt_ff + 17'd1;
               if (xcnt_in >= {1'b0, xlen_ff}) begin
                  phase_in = next_part(PH_EXTRA, flags_ff);
                  count_in = 4'd0;
               end
            end
            PH_NAME, PH_COMMENT: begin
               if (req.in_byte == 8'd0) begin
                  phase_in = next_part(phase_ff, flags_ff);
                  count_in = 4'd0;
               end
            end
            PH_HCRC: begin
               if (count_ff == 4'd0) begin
                  count_in = 4'd1;
               end else begin
                  phase_in = next_part(PH_HCRC, flags_ff);
                  count_in = 4'd0;
               end
            end
            PH_PAYLOAD: begin
               // trailer delay line, oldest byte at the head
               if (fill_ff < FILL_W'(TRAILER_BYTES)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end else begin
                  push.first_valid = 1'b1;
                  push.first       = '{out_byte: delay_ff[0], kind: KIND_PAYLOAD,
                                       member_done: 1'b0};
                  seen_in          = 1'b1;
               end
               for (int i = 0; i < TRAILER_BYTES - 1; i++)
                  delay_in[i] = delay_ff[i + 1];
               delay_in[TRAILER_BYTES - 1] = req.in_byte;
            end
            default: begin
            end
         endcase

         // end-of-member result
         if (req.in_final) begin
            if (phase_in == PH_PAYLOAD)
               end_kind = seen_in ? KIND_END_OK : KIND_TOO_SHORT;
            else if (phase_in == PH_DROP)
               end_kind = KIND_BAD_SIG;
            else
               end_kind = KIND_TRUNCATED;

            if (push.first_valid) begin
               push.second_valid = 1'b1;
               push.second = '{out_byte: 8'd0, kind: end_kind, member_done: 1'b1};
            end else begin
               push.first_valid = 1'b1;
               push.first = '{out_byte: 8'd0, kind: end_kind, member_done: 1'b1};
            end

            phase_in = PH_FIXED;
            count_in = 4'd0;
            flags_in = 5'd0;
            xlen_in  = 16'd0;
            xcnt_in  = 17'd0;
            fill_in  = '0;
            seen_in  = 1'b0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      if (reset) begin
         phase_ff <= PH_FIXED;
         count_ff <= 4'd0;
         flags_ff <= 5'd0;
         xlen_ff  <= 16'd0;
         xcnt_ff  <= 17'd0;
         fill_ff  <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
         xlen_ff  <= xlen_in;
         xcnt_ff  <= xcnt_in;
         fill_ff  <= fill_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

[rtl/ghs_out_queue.sv]
module ghs_out_queue
   import ghs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ghs_push_type push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ghs_rsp_type  rsp_data
);

   ghs_rsp_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] push_n;
   logic              pop;

   // room for the two results one transfer may bring
   assign room      = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // pointer and occupancy update
   always_comb begin
      push_n    = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + push_n - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid)
         entry_ff[wr_ptr_ff] <= push.first;
      if (push.second_valid)
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[tb/gzip_header_stripper_test.sv]
`timescale 1ns / 100ps

module gzip_header_stripper_test;
   import ghs_pkg::*;

   // parser states of the checker's own model
   typedef enum logic [3:0] {
      ST_FIXED, ST_XLEN, ST_EXTRA, ST_NAME, ST_COMMENT, ST_HCRC, ST_PAYLOAD, ST_DROP
   } parse_state_type;

   // one row of the directed stimulus; a typed row carries its own end result
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [2:0] kind;
   } dir_row_type;

   localparam int unsigned DIR_ROWS = 27;
   localparam dir_row_type DIRECTED [0:DIR_ROWS-1] = '{
      // one-byte members: wrong signature wins, bare first id byte is a short header
      '{8'h00, 1'b1, 1'b1, KIND_BAD_SIG},
      '{8'h1F, 1'b1, 1'b1, KIND_TRUNCATED},
      // every optional part, reserved flag bits set, zero extra length
      '{8'h1F, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h8B, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h08, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFE, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      // one payload byte ahead of the trailer
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h55, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hAA, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h7F, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFE, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b1, 1'b0, KIND_PAYLOAD}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ghs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ghs_rsp_type rsp_data;

   // model state
   parse_state_type hdr_phase;
   logic [3:0]      hdr_count;
   logic [4:0]      member_flags;
   logic [15:0]     xlen;
   logic [16:0]     xcount;
   logic [7:0]      held_bytes [TRAILER_BYTES];
   logic [3:0]      held_fill;
   logic            payload_sent;

   ghs_rsp_type     stripped_q [$];
   logic [7:0]      member_bytes [$];
   int unsigned     items_sent = 0;
   int unsigned     error_count = 0;
   logic            quiet = 1'b0;

   gzip_header_stripper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("gzip_header_stripper_test: done, errors");
      $finish;
   end

   // back to the start of a member
   task automatic clear_member_state();
      hdr_phase    = ST_FIXED;
      hdr_count    = '0;
      member_flags = '0;
      xlen         = '0;
      xcount       = '0;
      held_fill    = '0;
      payload_sent = 1'b0;
   endtask

   // first optional header part after 'from' that the flags ask for
   task automatic advance_from(input parse_state_type from);
      hdr_count = '0;
      if (from < ST_XLEN && member_flags[FL_EXTRA]) hdr_phase = ST_XLEN;
      else if (from < ST_NAME && member_flags[FL_NAME]) hdr_phase = ST_NAME;
      else if (from < ST_COMMENT && member_flags[FL_COMMENT]) hdr_phase = ST_COMMENT;
      else if (from < ST_HCRC && member_flags[FL_HCRC]) hdr_phase = ST_HCRC;
      else hdr_phase = ST_PAYLOAD;
   endtask

   // step the model by one accepted byte and queue what it strips out
   task automatic strip_byte(input logic [7:0] b, input logic fin);
      logic       bad;
      logic [2:0] end_kind;
      bad = 1'b0;
      case (hdr_phase)
         ST_FIXED: begin
            if (hdr_count == 0 && b != SIG_ID1) bad = 1'b1;
            if (hdr_count == 1 && b != SIG_ID2) bad = 1'b1;
            if (hdr_count == 2 && b != SIG_DEFLATE) bad = 1'b1;
            if (hdr_count == FLAG_INDEX) member_flags = b[4:0];
            if (bad) hdr_phase = ST_DROP;
            else if (hdr_count >= FIXED_LAST) advance_from(ST_FIXED);
            else hdr_count++;
         end
         ST_XLEN: begin
            if (hdr_count == 0) begin
               xlen      = {8'h00, b};
               hdr_count = 1;
            end else begin
               xlen[15:8] = b;
               hdr_count  = '0;
               xcount     = '0;
               if (xlen == 0) advance_from(ST_EXTRA);
               else hdr_phase = ST_EXTRA;
            end
         end
         ST_EXTRA: begin
            xcount++;
            if (xcount >= {1'b0, xlen}) advance_from(ST_EXTRA);
         end
         ST_NAME: begin
            if (b == 8'h00) advance_from(ST_NAME);
         end
         ST_COMMENT: begin
            if (b == 8'h00) advance_from(ST_COMMENT);
         end
         ST_HCRC: begin
            if (hdr_count == 0) hdr_count = 1;
            else advance_from(ST_HCRC);
         end
         ST_PAYLOAD: begin
            if (held_fill < TRAILER_BYTES) begin
               held_bytes[held_fill] = b;
               held_fill++;
            end else begin
               stripped_q.push_back('{out_byte: held_bytes[0], kind: KIND_PAYLOAD,
                                      member_done: 1'b0});
               for (int i = 0; i < TRAILER_BYTES - 1; i++) held_bytes[i] = held_bytes[i+1];
               held_bytes[TRAILER_BYTES-1] = b;
               payload_sent = 1'b1;
            end
         end
         default: ;
      endcase

      if (fin) begin
         if (hdr_phase == ST_PAYLOAD) end_kind = payload_sent ? KIND_END_OK : KIND_TOO_SHORT;
         else if (hdr_phase == ST_DROP) end_kind = KIND_BAD_SIG;
         else end_kind = KIND_TRUNCATED;
         stripped_q.push_back('{out_byte: 8'h00, kind: end_kind, member_done: 1'b1});
         clear_member_state();
      end
   endtask

   // offer one byte, wait for its transfer, then predict
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input logic [2:0] kind);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_final: fin};
      do @(posedge clock); while (req_stall);
      items_sent++;
      quiet = (items_sent >= 650);
      strip_byte(b, fin);
      if (typed) stripped_q[$] = '{out_byte: 8'h00, kind: kind, member_done: 1'b1};
      @(negedge clock);
   endtask

   // short run of nonzero bytes closed by a zero
   task automatic push_zstring();
      repeat ($urandom_range(0, 6)) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
   endtask

   // one member: mostly well formed, some noise, bad signatures and cut headers
   task automatic build_member();
      int unsigned shape;
      int unsigned n;
      int unsigned hdr_len;
      int unsigned pick;
      logic [7:0]  flg;
      member_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         n = $urandom_range(1, 12);
         repeat (n) member_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1)) member_bytes[0] = SIG_ID1;
         return;
      end
      member_bytes.push_back(SIG_ID1);
      member_bytes.push_back(SIG_ID2);
      member_bytes.push_back(SIG_DEFLATE);
      flg = 8'($urandom);
      member_bytes.push_back(flg);
      repeat (6) member_bytes.push_back(8'($urandom));
      if (flg[FL_EXTRA]) begin
         pick = $urandom_range(0, 39);
         if (pick < 5) n = 0;
         else if (pick == 39) n = $urandom_range(256, 280);
         else n = $urandom_range(1, 12);
         member_bytes.push_back(n[7:0]);
         member_bytes.push_back(n[15:8]);
         repeat (n) member_bytes.push_back(8'($urandom));
      end
      if (flg[FL_NAME]) push_zstring();
      if (flg[FL_COMMENT]) push_zstring();
      if (flg[FL_HCRC]) begin
         member_bytes.push_back(8'($urandom));
         member_bytes.push_back(8'($urandom));
      end
      hdr_len = member_bytes.size();
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, TRAILER_BYTES)
                                      : $urandom_range(TRAILER_BYTES + 1, 32);
      repeat (n) member_bytes.push_back(8'($urandom));

      // broken variants
      if (shape < 20) begin
         pick = $urandom_range(0, 2);
         member_bytes[pick] = member_bytes[pick] ^ 8'($urandom_range(1, 255));
         if ($urandom_range(0, 2) == 0) member_bytes = member_bytes[0:pick];
      end else if (shape < 30) begin
         member_bytes = member_bytes[0:$urandom_range(0, hdr_len - 2)];
      end
   endtask

   // reset, directed table, random members, drain
   initial begin
      bit paused;
      paused = 1'b0;
      clear_member_state();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIR_ROWS; r++)
         send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].kind);

      while (items_sent < 750) begin
         // sender holds off until every result is in
         if (!paused && items_sent >= 500) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(negedge clock); while (stripped_q.size() != 0);
         end
         build_member();
         foreach (member_bytes[i])
            send_byte(member_bytes[i], i == member_bytes.size() - 1, 1'b0, KIND_PAYLOAD);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (stripped_q.size() != 0);
      repeat (16) @(negedge clock);
      if (error_count == 0)
         $display("gzip_header_stripper_test: done, clean");
      else
         $display("gzip_header_stripper_test: done, errors");
      $finish;
   end

   // receiver stall: random bursts plus one long hold that backs up the block
   initial begin
      bit held_long;
      held_long = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_long && items_sent >= 300) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      ghs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stripped_q.size() == 0) begin
            $error("unexpected result: out_byte %h kind %0d member_done %b",
                   rsp_data.out_byte, rsp_data.kind, rsp_data.member_done);
            error_count++;
         end else begin
            want = stripped_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               error_count++;
            end
            if (rsp_data.member_done !== want.member_done) begin
               $error("member_done: expected %b, got %b", want.member_done,
                      rsp_data.member_done);
               error_count++;
            end
         end
      end
   end

endmodule
